>>> sv/vvsl_pkg.sv
package vvsl_pkg;

   localparam int AXES       = 5;
   localparam int AXIS_W     = 3;
   localparam int VAL_W      = 16;
   localparam int DIFF_W     = VAL_W + 1;
   localparam int SQ_W       = 2 * VAL_W;
   localparam int SUM_W      = SQ_W + 4;
   localparam int STEP_W     = 15;
   localparam int LIM2_W     = 2 * STEP_W;
   localparam int NUM_W      = SQ_W + LIM2_W;
   localparam int QUOT_W     = LIM2_W;
   localparam int ROOT_W     = LIM2_W / 2;
   localparam int ROOT_REM_W = ROOT_W + 2;
   localparam int DIV_CNT_W  = $clog2(NUM_W);
   localparam int SQ_CNT_W   = $clog2(ROOT_W);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0] MAX_STEP_RESET = STEP_W'(2048);

   typedef enum logic [0:0] {
      CSR_MAX_STEP = 1'b0
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHECK,
      ST_MUL1,
      ST_MUL2,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_APPLY,
      ST_OUT
   } state_type;

endpackage

>>> sv/vvsl_div.sv
module vvsl_div
   import vvsl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [SUM_W-1:0]  divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     sh_ff, sh_in;
   logic [SUM_W:0]       trial;
   logic                 qbit;

   // shift one dividend bit into the remainder per cycle, quotient bits fill from below
   always_comb begin
      trial   = {rem_ff, sh_ff[NUM_W-1]};
      qbit    = (trial >= {1'b0, divisor});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         sh_in   = dividend;
      end else if (busy_ff) begin
         rem_in = qbit ? SUM_W'(trial - {1'b0, divisor}) : trial[SUM_W-1:0];
         sh_in  = {sh_ff[NUM_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   assign done     = done_ff;
   assign quotient = sh_ff[QUOT_W-1:0];

endmodule

>>> sv/vvsl_sqrt.sv
module vvsl_sqrt
   import vvsl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [QUOT_W-1:0] radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [SQ_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ROOT_REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [QUOT_W-1:0]       sh_ff, sh_in;
   logic [ROOT_REM_W+1:0]   cur;
   logic [ROOT_REM_W+1:0]   trial;
   logic                    fits;

   // one root bit per cycle: bring down two radicand bits, try (root << 2) | 1
   always_comb begin
      cur     = {rem_ff, sh_ff[QUOT_W-1 -: 2]};
      trial   = (ROOT_REM_W + 2)'({root_ff, 2'b01});
      fits    = (cur >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      sh_in   = sh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         root_in = '0;
         sh_in   = radicand;
      end else if (busy_ff) begin
         rem_in  = fits ? ROOT_REM_W'(cur - trial) : cur[ROOT_REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         sh_in   = {sh_ff[QUOT_W-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      sh_ff   <= sh_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> sv/vector_velocity_step_limiter.sv
// Channel   Direction  Handshake               Beat
// req_      in         req_valid / req_ready   mode and five target components
// rsp_      out        rsp_valid / rsp_ready   five commanded components, limit flag
// csr_      in         APB psel / penable      max_step at byte address 0
//
// Pass-through and preset beats go from accept through the sum, check and output states.
// A limited beat also runs, per axis, a 62-bit serial divide and a 15-bit serial
// square root, both bit-per-cycle units.
// One beat at a time; the result register frees the input side once loaded.
// Reset is synchronous, clears the stored command and returns max_step to 2048.
module vector_velocity_step_limiter
   import vvsl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic signed [VAL_W-1:0] req_target_x,
   input  logic signed [VAL_W-1:0] req_target_y,
   input  logic signed [VAL_W-1:0] req_target_z,
   input  logic signed [VAL_W-1:0] req_target_a,
   input  logic signed [VAL_W-1:0] req_target_b,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_out_x,
   output logic signed [VAL_W-1:0] rsp_out_y,
   output logic signed [VAL_W-1:0] rsp_out_z,
   output logic signed [VAL_W-1:0] rsp_out_a,
   output logic signed [VAL_W-1:0] rsp_out_b,
   output logic                    rsp_was_limited,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   state_type state_ff, state_in;

   logic signed [VAL_W-1:0] tgt_ff [AXES];
   logic signed [VAL_W-1:0] tgt_in [AXES];
   logic signed [VAL_W-1:0] last_ff [AXES];
   logic signed [VAL_W-1:0] last_in [AXES];
   logic signed [VAL_W-1:0] rsp_ff [AXES];
   logic signed [VAL_W-1:0] rsp_in [AXES];
   logic                    mode_ff, mode_in;
   logic [SUM_W-1:0]        s_ff, s_in;
   logic [LIM2_W-1:0]       lim2_ff, lim2_in;
   logic [AXIS_W-1:0]       axis_ff, axis_in;
   logic [SQ_W-1:0]         a2_ff, a2_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic                    limited_ff, limited_in;
   logic [STEP_W-1:0]       max_step_ff, max_step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_lim_ff, rsp_lim_in;

   logic                    accept;
   logic                    div_start, sq_start, rsp_load;
   logic                    div_done, sq_done;
   logic [QUOT_W-1:0]       quot;
   logic [ROOT_W-1:0]       root;
   logic                    csr_wr;
   logic signed [DIFF_W-1:0] d_cur;
   logic [DIFF_W-1:0]       d_neg;
   logic [VAL_W-1:0]        abs_cur;
   logic [SQ_W-1:0]         sq_cur;
   logic                    lim_cond;
   logic signed [DIFF_W-1:0] step_val;
   logic signed [DIFF_W-1:0] new_val;

   vvsl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (s_ff),
      .done     (div_done),
      .quotient (quot)
   );

   vvsl_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (quot),
      .done     (sq_done),
      .root     (root)
   );

   assign accept = req_valid && req_ready;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == CSR_MAX_STEP);

   always_comb begin
      d_cur    = {tgt_ff[axis_ff][VAL_W-1], tgt_ff[axis_ff]}
                 - {last_ff[axis_ff][VAL_W-1], last_ff[axis_ff]};
      d_neg    = DIFF_W'(~d_cur + 1'b1);
      abs_cur  = d_cur[DIFF_W-1] ? d_neg[VAL_W-1:0] : d_cur[VAL_W-1:0];
      sq_cur   = abs_cur * abs_cur;
      lim_cond = !mode_ff && (s_ff > SUM_W'(lim2_ff));
      step_val = DIFF_W'({2'b00, root});
      new_val  = d_cur[DIFF_W-1]
                 ? DIFF_W'($signed({last_ff[axis_ff][VAL_W-1], last_ff[axis_ff]}) - step_val)
                 : DIFF_W'($signed({last_ff[axis_ff][VAL_W-1], last_ff[axis_ff]}) + step_val);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_SUM;
         ST_SUM:      if (axis_ff == AXIS_W'(AXES - 1)) state_in = ST_CHECK;
         ST_CHECK:    state_in = lim_cond ? ST_MUL1 : ST_OUT;
         ST_MUL1:     state_in = ST_MUL2;
         ST_MUL2:     state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_SQ_GO;
         ST_SQ_GO:    state_in = ST_SQ_WAIT;
         ST_SQ_WAIT:  if (sq_done) state_in = ST_APPLY;
         ST_APPLY:    state_in = (axis_ff == AXIS_W'(AXES - 1)) ? ST_OUT : ST_MUL1;
         ST_OUT:      if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      sq_start  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_DIV_GO: div_start = 1'b1;
         ST_SQ_GO:  sq_start  = 1'b1;
         ST_OUT:    rsp_load  = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   // datapath
   always_comb begin
      tgt_in      = tgt_ff;
      last_in     = last_ff;
      rsp_in      = rsp_ff;
      mode_in     = mode_ff;
      s_in        = s_ff;
      lim2_in     = lim2_ff;
      axis_in     = axis_ff;
      a2_in       = a2_ff;
      num_in      = num_ff;
      limited_in  = limited_ff;
      rsp_lim_in  = rsp_lim_ff;
      max_step_in = csr_wr ? csr_pwdata[STEP_W-1:0] : max_step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         tgt_in[0]  = req_target_x;
         tgt_in[1]  = req_target_y;
         tgt_in[2]  = req_target_z;
         tgt_in[3]  = req_target_a;
         tgt_in[4]  = req_target_b;
         mode_in    = req_mode;
         lim2_in    = max_step_ff * max_step_ff;
         s_in       = '0;
         axis_in    = '0;
         limited_in = 1'b0;
      end

      case (state_ff)
         ST_SUM: begin
            s_in    = s_ff + SUM_W'(sq_cur);
            axis_in = (axis_ff == AXIS_W'(AXES - 1)) ? '0 : AXIS_W'(axis_ff + 1'b1);
         end
         ST_CHECK: begin
            if (lim_cond) begin
               limited_in = 1'b1;
            end else begin
               last_in = tgt_ff;
            end
         end
         ST_MUL1: a2_in  = sq_cur;
         ST_MUL2: num_in = a2_ff * lim2_ff;
         ST_APPLY: begin
            last_in[axis_ff] = new_val[VAL_W-1:0];
            axis_in          = AXIS_W'(axis_ff + 1'b1);
         end
         default: ;
      endcase

      if (rsp_load) begin
         rsp_in       = last_ff;
         rsp_lim_in   = limited_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_step_ff  <= MAX_STEP_RESET;
         axis_ff      <= '0;
         for (int i = 0; i < AXES; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_step_ff  <= max_step_in;
         axis_ff      <= axis_in;
         last_ff      <= last_in;
      end
      tgt_ff     <= tgt_in;
      rsp_ff     <= rsp_in;
      mode_ff    <= mode_in;
      s_ff       <= s_in;
      lim2_ff    <= lim2_in;
      a2_ff      <= a2_in;
      num_ff     <= num_in;
      limited_ff <= limited_in;
      rsp_lim_ff <= rsp_lim_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_ff[0];
   assign rsp_out_y       = rsp_ff[1];
   assign rsp_out_z       = rsp_ff[2];
   assign rsp_out_a       = rsp_ff[3];
   assign rsp_out_b       = rsp_ff[4];
   assign rsp_was_limited = rsp_lim_ff;
   assign csr_pready      = 1'b1;
   assign csr_prdata      = (csr_paddr[2] == CSR_MAX_STEP)
                            ? CSR_DATA_W'(max_step_ff) : '0;

`ifndef SYNTHESIS
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_root_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY |-> {1'b0, root} <= abs_cur)
      else $error("scaled step exceeds the requested change");

   a_limit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && lim_cond) |-> s_ff != '0)
      else $error("limiting taken with zero change");

   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the output state");
`endif

endmodule

>>> bench/vvsl_checker.sv
`timescale 1ns / 1ps
module vvsl_checker
   import vvsl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_mode,
   input  logic signed [VAL_W-1:0] req_target_x,
   input  logic signed [VAL_W-1:0] req_target_y,
   input  logic signed [VAL_W-1:0] req_target_z,
   input  logic signed [VAL_W-1:0] req_target_a,
   input  logic signed [VAL_W-1:0] req_target_b,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [VAL_W-1:0] rsp_out_x,
   input  logic signed [VAL_W-1:0] rsp_out_y,
   input  logic signed [VAL_W-1:0] rsp_out_z,
   input  logic signed [VAL_W-1:0] rsp_out_a,
   input  logic signed [VAL_W-1:0] rsp_out_b,
   input  logic                    rsp_was_limited,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                    csr_pready,
   output int                      fail_count,
   output int                      pending
);

   typedef struct packed {
      logic signed [AXES-1:0][VAL_W-1:0] vec;
      logic                              limited;
   } command_type;

   logic [STEP_W-1:0]       step_limit;
   logic signed [VAL_W-1:0] held_command [AXES];
   command_type             command_queue [$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] cand;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= v) root = cand;
      end
      return root;
   endfunction

   task automatic predict_command(input logic mode, input logic signed [VAL_W-1:0] tgt [AXES]);
      logic signed [DIFF_W-1:0] diff [AXES];
      logic [63:0]              mag;
      logic [63:0]              sum_sq;
      logic [63:0]              lim_sq;
      logic [63:0]              q;
      command_type              c;
      sum_sq = 0;
      lim_sq = 64'(step_limit) * 64'(step_limit);
      c.limited = 1'b0;
      if (mode) begin
         for (int i = 0; i < AXES; i++) held_command[i] = tgt[i];
      end else begin
         for (int i = 0; i < AXES; i++) begin
            diff[i] = DIFF_W'(tgt[i]) - DIFF_W'(held_command[i]);
            mag = diff[i] < 0 ? 64'(-diff[i]) : 64'(diff[i]);
            sum_sq += mag * mag;
         end
         if (sum_sq > lim_sq) begin
            c.limited = 1'b1;
            for (int i = 0; i < AXES; i++) begin
               mag = diff[i] < 0 ? 64'(-diff[i]) : 64'(diff[i]);
               q = int_sqrt(((mag * mag) * lim_sq) / sum_sq);
               held_command[i] = diff[i] < 0 ? held_command[i] - VAL_W'(q)
                                             : held_command[i] + VAL_W'(q);
            end
         end else begin
            for (int i = 0; i < AXES; i++) held_command[i] = tgt[i];
         end
      end
      for (int i = 0; i < AXES; i++) c.vec[i] = held_command[i];
      command_queue.push_back(c);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic signed [VAL_W-1:0] tgt [AXES];
      logic signed [VAL_W-1:0] got [AXES];
      command_type             want;
      if (reset) begin
         step_limit = MAX_STEP_RESET;
         for (int i = 0; i < AXES; i++) held_command[i] = '0;
         command_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CSR_ADDR_W'(4 * CSR_MAX_STEP))
            step_limit = csr_pwdata[STEP_W-1:0];
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_a, rsp_out_b};
            if (command_queue.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = command_queue.pop_front();
               for (int i = 0; i < AXES; i++)
                  if (got[i] !== want.vec[i])
                     report_mismatch($sformatf("axis %0d", i), got[i], want.vec[i]);
               if (rsp_was_limited !== want.limited)
                  report_mismatch("was_limited", rsp_was_limited, want.limited);
            end
         end
         if (req_valid && req_ready) begin
            tgt = '{req_target_x, req_target_y, req_target_z, req_target_a, req_target_b};
            predict_command(req_mode, tgt);
         end
      end
      pending = command_queue.size();
   end

endmodule

>>> bench/vector_velocity_step_limiter_tb.sv
`timescale 1ns / 1ps
module vector_velocity_step_limiter_tb;
   import vvsl_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_mode = 1'b0;
   logic signed [VAL_W-1:0] req_target_x = '0;
   logic signed [VAL_W-1:0] req_target_y = '0;
   logic signed [VAL_W-1:0] req_target_z = '0;
   logic signed [VAL_W-1:0] req_target_a = '0;
   logic signed [VAL_W-1:0] req_target_b = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_a, rsp_out_b;
   logic                    rsp_was_limited;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;
   int                      fail_count;
   int                      pending;
   int                      idle_cycles = 0;
   bit                      hold_rsp = 1'b0;
   logic signed [VAL_W-1:0] base [AXES];

   always #1 clock = ~clock;

   vector_velocity_step_limiter dut (.*);

   vvsl_checker checker_i (.*);

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   // receiver: random stalls, one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(negedge clock);
            hold_rsp = 1'b0;
         end
         n = gap_len();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic send_beat(input logic mode, input logic signed [VAL_W-1:0] v [AXES],
                            input bit gaps);
      int n;
      n = gaps ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_target_x <= v[0];
      req_target_y <= v[1];
      req_target_z <= v[2];
      req_target_a <= v[3];
      req_target_b <= v[4];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      // no beat is still under way once pending is back to zero
      repeat (20) @(negedge clock);
   endtask

   task automatic write_max_step(input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * CSR_MAX_STEP);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [VAL_W-1:0] near(input logic signed [VAL_W-1:0] c,
                                                   input int span);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return VAL_W'(v);
   endfunction

   task automatic random_beats(input int count, input int span, input bit gaps);
      logic signed [VAL_W-1:0] v [AXES];
      logic                    mode;
      int                      r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         mode = (r < 8);
         for (int i = 0; i < AXES; i++) begin
            if (r < 20) v[i] = VAL_W'($urandom());
            else if (r < 25) v[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            else v[i] = near(base[i], span);
            base[i] = v[i];
         end
         send_beat(mode, v, gaps);
      end
   endtask

   initial begin
      logic signed [VAL_W-1:0] v [AXES];
      logic [CSR_DATA_W-1:0]   steps [6];
      steps = '{32'd1, 32'd32767, 32'hffff_0800, 32'd0, 32'd300, 32'd9000};
      for (int i = 0; i < AXES; i++) base[i] = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset limit, extremes, preset, exact-length step
      v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      send_beat(1'b0, v, 1'b0);
      v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      send_beat(1'b0, v, 1'b0);
      send_beat(1'b1, v, 1'b0);
      v = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh7fff, 16'sh8000};
      send_beat(1'b1, v, 1'b0);
      send_beat(1'b0, v, 1'b0);
      v = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
      send_beat(1'b1, v, 1'b0);
      v = '{16'sd2048, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
      send_beat(1'b0, v, 1'b0);
      v = '{16'sd2048, 16'sd1229, 16'sd1638, 16'sh0000, 16'sh0000};
      send_beat(1'b0, v, 1'b0);
      v = '{16'sd2048, 16'sd1229, 16'sd1638, 16'sd1, 16'sh0000};
      send_beat(1'b0, v, 1'b0);
      v = '{-16'sd5, 16'sd3, -16'sd1, 16'sd1, -16'sd2};
      send_beat(1'b0, v, 1'b0);
      drain();

      foreach (steps[s]) begin
         write_max_step(steps[s]);
         v = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
         send_beat(1'b0, v, 1'b0);
         v = '{16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234};
         send_beat(1'b0, v, 1'b0);
         random_beats(170, (s % 2) ? 400 : 4000, 1'b1);
         if (s == 1) begin
            hold_rsp = 1'b1;
            random_beats(10, 2000, 1'b0);
         end
         // pause until everything is back, then resume without gaps
         drain();
         random_beats(20, 3000, 1'b0);
         drain();
      end

      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
